// ===== hdl/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define UPFR_ASSERT_CLK(label, clk_sig, rst_n_sig, prop) \
	label: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) prop) \
		else $error("upfr assertion failed");

// same, on the usual clk / arst_n pair
`define UPFR_ASSERT(label, prop) \
	`UPFR_ASSERT_CLK(label, clk, arst_n, prop)

`endif

// ===== hdl/upfr_pkg.sv =====
// shared types and constants for the uart position frame receiver
// no dependencies
package upfr_pkg;

	localparam int BYTE_W = 8;
	localparam int NUM_CELLS = 6;
	localparam int NUM_PAYLOAD = 4;
	localparam int OUT_W = NUM_PAYLOAD * BYTE_W;
	localparam int IDX_W = 3;
	localparam int CFG_ADDR_W = 1;

	typedef logic [BYTE_W-1:0] byte_t;
	typedef logic [IDX_W-1:0] frame_idx_t;

	// register indexes of the configuration port
	localparam logic [CFG_ADDR_W-1:0] REG_START_CODE = 1'b0;
	localparam logic [CFG_ADDR_W-1:0] REG_STOP_CODE = 1'b1;

	localparam byte_t RESET_START_CODE = 8'hAA;
	localparam byte_t RESET_STOP_CODE = 8'h55;

	// frame position codes
	localparam frame_idx_t IDX_HUNT = 3'd0;
	localparam frame_idx_t IDX_LAST = 3'd7;

endpackage

// ===== hdl/upfr_cell.sv =====
// one byte cell of the frame store chain
// depends on upfr_pkg
module upfr_cell (
	input  logic           clk,
	input  logic           shift,
	input  upfr_pkg::byte_t d,
	output upfr_pkg::byte_t q
);
	import upfr_pkg::*;

	byte_t byte_q;

	always_ff @(posedge clk) begin
		if (shift) begin
			byte_q <= d;
		end
	end

	assign q = byte_q;

endmodule

// ===== hdl/uart_position_frame_receiver.sv =====
// uart position frame receiver: deframes 8-byte position frames with xor checks
// depends on upfr_pkg and upfr_cell
//
// usage:
//   s_axis carries one received uart byte per item in tdata[7:0].
//   m_axis carries one item per good frame: tdata = x, y, count a, count b
//   from the lowest byte up.
//   frame layout: start code, x, y, count a, count b, x^y, a^b, stop code.
//   while hunting, bytes other than the start code are dropped. the six
//   bytes after the start shift down a chain of six byte cells, one cell
//   step per accepted item. on the eighth byte the stop code and both
//   xor checks are tested; only a passing frame loads the output register.
//   latency: the result is valid the cycle after the stop byte is accepted.
//   throughput: one byte per cycle while s_axis_tready is high, set by the
//   single output register and the one-step cell chain.
//   stall: s_axis_tready drops only while a result waits and m_axis_tready
//   is low; a result is taken and a new byte accepted in the same cycle.
//   reset: arst_n clears the frame position (hunting), the output valid
//   and the codes to 0xAA / 0x55; the cell contents are not cleared.
//   cfg: cfg_addr 0 writes the start code, 1 the stop code.
module uart_position_frame_receiver (
	input  logic                              clk,
	input  logic                              arst_n,
	// configuration write port
	input  logic                              cfg_we,
	input  logic [upfr_pkg::CFG_ADDR_W-1:0]   cfg_addr,
	input  logic [upfr_pkg::BYTE_W-1:0]       cfg_wdata,
	// input bytes
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [upfr_pkg::BYTE_W-1:0]       s_axis_tdata,  // [7:0] rx_byte
	// decoded frames
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// [7:0] pos_x, [15:8] pos_y, [23:16] count_a, [31:24] count_b
	output logic [upfr_pkg::OUT_W-1:0]        m_axis_tdata
);
	import upfr_pkg::*;

	byte_t start_code_q;
	byte_t stop_code_q;
	frame_idx_t idx_q;
	logic out_vld_q;
	logic [OUT_W-1:0] out_data_q;

	logic accept;
	logic in_body;
	logic at_last;
	logic frame_ok;
	byte_t chain [NUM_CELLS+1];

	// input side stalls only while a result waits downstream
	assign s_axis_tready = !out_vld_q || m_axis_tready;
	assign accept = s_axis_tvalid && s_axis_tready;

	assign in_body = (idx_q != IDX_HUNT) && (idx_q != IDX_LAST);
	assign at_last = (idx_q == IDX_LAST);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_code_q <= RESET_START_CODE;
			stop_code_q <= RESET_STOP_CODE;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_START_CODE: start_code_q <= cfg_wdata;
				REG_STOP_CODE:  stop_code_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// byte cell chain: new byte enters cell 0, older bytes move up.
	// after six body bytes: cell5 x, cell4 y, cell3 a, cell2 b, cell1 x^y, cell0 a^b
	assign chain[0] = s_axis_tdata;

	for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
		upfr_cell u_cell (
			.clk   (clk),
			.shift (accept && in_body),
			.d     (chain[i]),
			.q     (chain[i+1])
		);
	end

	// stop byte plus both xor checks
	assign frame_ok = (s_axis_tdata == stop_code_q)
		&& ((chain[6] ^ chain[5]) == chain[2])
		&& ((chain[4] ^ chain[3]) == chain[1]);

	// frame position: hunt, then count through the eight bytes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= IDX_HUNT;
		end else if (accept) begin
			if (idx_q == IDX_HUNT) begin
				if (s_axis_tdata == start_code_q) begin
					idx_q <= idx_q + 3'd1;
				end
			end else if (at_last) begin
				idx_q <= IDX_HUNT;
			end else begin
				idx_q <= idx_q + 3'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (accept && at_last && frame_ok) begin
			out_vld_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && at_last && frame_ok) begin
			out_data_q <= {chain[3], chain[4], chain[5], chain[6]};
		end
	end

	assign m_axis_tvalid = out_vld_q;
	assign m_axis_tdata = out_data_q;

endmodule

// ===== hdl/upfr_checker.sv =====
// port-level checks for the uart position frame receiver, bound to the top level
// depends on upfr_pkg and assert_macros.svh
`include "assert_macros.svh"

module upfr_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [upfr_pkg::OUT_W-1:0]  m_axis_tdata
);
	import upfr_pkg::*;

	// a waiting result stays offered with the same data
	`UPFR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))

	// input stalls whenever a result is blocked
	`UPFR_ASSERT(a_in_stall, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)

	// a new result follows an accepted input item
	`UPFR_ASSERT(a_out_cause, m_axis_tvalid && !$past(m_axis_tvalid && !m_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))

	// frames are eight bytes long, so results never come back to back
	`UPFR_ASSERT(a_out_spacing, m_axis_tvalid && m_axis_tready |=> !m_axis_tvalid)

endmodule

bind uart_position_frame_receiver upfr_checker u_upfr_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
